// ===== rtl/core/fpa_pkg.sv =====
// fixed partition allocator: shared types and constants
// used by the interfaces, the controller, the datapath and the top level
`timescale 1ns / 1ps
`default_nettype none

package fpa_pkg;

	localparam int AMOUNT_W = 16;
	localparam int ENTRY_W  = 4;
	localparam int REQ_W    = 8;
	localparam int POLICY_W = 2;
	localparam int ACTIVE_W = 5;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 5;

	localparam logic [POLICY_W-1:0] POL_BEST  = 2'd0;
	localparam logic [POLICY_W-1:0] POL_WORST = 2'd1;
	localparam logic [POLICY_W-1:0] POL_FIRST = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_POLICY = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ACTIVE = 1'd1;

	localparam logic KIND_LOAD    = 1'b0;
	localparam logic KIND_REQUEST = 1'b1;

	localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 5'd16;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic start;
		logic scan;
		logic finish;
	} fpa_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic scan_end;
		logic out_free;
	} fpa_stat_t;

endpackage

`default_nettype wire

// ===== rtl/core/fpa_in_if.sv =====
// input channel of the partition allocator: load and request items
// depends on fpa_pkg for field widths
`timescale 1ns / 1ps
`default_nettype none

interface fpa_in_if import fpa_pkg::*; ;
	logic                valid;
	logic                ready;
	logic                kind;
	logic [ENTRY_W-1:0]  entry_index;
	logic [AMOUNT_W-1:0] amount;
	logic [REQ_W-1:0]    requester;

	modport source (output valid, output kind, output entry_index, output amount,
		output requester, input ready);
	modport sink (input valid, input kind, input entry_index, input amount,
		input requester, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/fpa_out_if.sv =====
// result channel of the partition allocator
// depends on fpa_pkg for field widths
`timescale 1ns / 1ps
`default_nettype none

interface fpa_out_if import fpa_pkg::*; ;
	logic                valid;
	logic                ready;
	logic                granted;
	logic [ENTRY_W-1:0]  chosen_index;
	logic [AMOUNT_W-1:0] chosen_size;
	logic [REQ_W-1:0]    requester_echo;

	modport source (output valid, output granted, output chosen_index, output chosen_size,
		output requester_echo, input ready);
	modport sink (input valid, input granted, input chosen_index, input chosen_size,
		input requester_echo, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/fixed_partition_allocator_core.sv =====
// fixed partition allocator top level: joins controller and datapath
// depends on fpa_pkg, fpa_in_if, fpa_out_if, fpa_ctrl and fpa_dp
//
//   channel  | dir | transfer
//   ---------+-----+---------------------------------------------------
//   in_ch    | in  | load (kind 0) or request (kind 1) item
//   out_ch   | out | one result per request
//   cfg_*    | in  | register write when cfg_we is high, no back-pressure
//
// a request is accepted, then min(active_partitions, MAX_PARTITIONS) entries are scanned
// through the single read port of the size memory, the last compare settles, and the
// chosen entry, if any, is marked taken.
// reset clears config, taken flags and control; no clearing pass is needed.
// a stalled output holds the finished request in its final state until the result
// register frees; a pending result does not stop loads or the next scan.
`timescale 1ns / 1ps
`default_nettype none

module fixed_partition_allocator_core import fpa_pkg::*; #(
	parameter int MAX_PARTITIONS = 16
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	fpa_in_if.sink                     in_ch,
	fpa_out_if.source                  out_ch
);

	fpa_cmd_t  cmd;
	fpa_stat_t stat;

	fpa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_kind  (in_ch.kind),
		.in_ready (in_ch.ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	fpa_dp #(
		.MAX_PARTITIONS (MAX_PARTITIONS)
	) u_dp (
		.clk                (clk),
		.arst_n             (arst_n),
		.cfg_we             (cfg_we),
		.cfg_index          (cfg_index),
		.cfg_data           (cfg_data),
		.in_entry_index     (in_ch.entry_index),
		.in_amount          (in_ch.amount),
		.in_requester       (in_ch.requester),
		.cmd                (cmd),
		.stat               (stat),
		.out_valid          (out_ch.valid),
		.out_ready          (out_ch.ready),
		.out_granted        (out_ch.granted),
		.out_chosen_index   (out_ch.chosen_index),
		.out_chosen_size    (out_ch.chosen_size),
		.out_requester_echo (out_ch.requester_echo)
	);

endmodule

`default_nettype wire

// ===== rtl/core/fpa_ctrl.sv =====
// allocator controller: one-hot state machine that sequences load, scan and finish
// depends on fpa_pkg for the command and status structs
`timescale 1ns / 1ps
`default_nettype none

module fpa_ctrl import fpa_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	input  wire logic      in_kind,
	output logic           in_ready,
	input  wire fpa_stat_t stat,
	output fpa_cmd_t       cmd
);

	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_SCAN   = 3'b010,
		ST_FINISH = 3'b100
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d    = state_q;
		in_ready   = 1'b0;
		cmd        = '0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (in_kind == KIND_LOAD) begin
						cmd.load = 1'b1;
					end else begin
						cmd.start = 1'b1;
						state_d   = ST_SCAN;
					end
				end
			end
			ST_SCAN: begin
				// last compare settles on the edge that leaves this state
				if (stat.scan_end) begin
					state_d = ST_FINISH;
				end else begin
					cmd.scan = 1'b1;
				end
			end
			ST_FINISH: begin
				if (stat.out_free) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/fpa_dp.sv =====
// allocator datapath: config registers, size memory, taken flags, scan compare
// and the result register; depends on fpa_pkg
`timescale 1ns / 1ps
`default_nettype none

module fpa_dp import fpa_pkg::*; #(
	parameter int MAX_PARTITIONS = 16
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic [ENTRY_W-1:0]    in_entry_index,
	input  wire logic [AMOUNT_W-1:0]   in_amount,
	input  wire logic [REQ_W-1:0]      in_requester,
	input  wire fpa_cmd_t              cmd,
	output fpa_stat_t                  stat,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic                       out_granted,
	output logic [ENTRY_W-1:0]         out_chosen_index,
	output logic [AMOUNT_W-1:0]        out_chosen_size,
	output logic [REQ_W-1:0]           out_requester_echo
);

	localparam int IDX_W = (MAX_PARTITIONS > 1) ? $clog2(MAX_PARTITIONS) : 1;
	localparam int CNT_W = $clog2(MAX_PARTITIONS + 1);
	localparam int CMP_W = (CNT_W > ACTIVE_W) ? CNT_W : ACTIVE_W;

	logic [POLICY_W-1:0] policy_q;
	logic [ACTIVE_W-1:0] active_q;

	logic [AMOUNT_W-1:0] size_mem [MAX_PARTITIONS];
	logic [MAX_PARTITIONS-1:0] taken_q;

	logic [CNT_W-1:0]    cnt_q;
	logic [AMOUNT_W-1:0] amount_q;
	logic [REQ_W-1:0]    req_q;

	logic                vld_s1;
	logic                taken_s1;
	logic [AMOUNT_W-1:0] size_s1;
	logic [IDX_W-1:0]    idx_s1;

	logic                found_q;
	logic [IDX_W-1:0]    pick_q;
	logic [AMOUNT_W-1:0] best_q;

	logic                out_valid_q;
	logic                granted_q;
	logic [ENTRY_W-1:0]  chosen_index_q;
	logic [AMOUNT_W-1:0] chosen_size_q;
	logic [REQ_W-1:0]    requester_echo_q;

	logic [IDX_W-1:0] rd_addr;
	logic [IDX_W-1:0] ld_addr;
	logic             ld_in_range;
	logic             in_limit;
	logic             fit;
	logic             better;

	assign rd_addr     = cnt_q[IDX_W-1:0];
	assign ld_addr     = IDX_W'(in_entry_index);
	assign ld_in_range = (32'(in_entry_index) < 32'(MAX_PARTITIONS));
	assign in_limit    = (CMP_W'(cnt_q) < CMP_W'(active_q))
		&& (CMP_W'(cnt_q) < CMP_W'(MAX_PARTITIONS));

	assign stat.scan_end = !in_limit;
	assign stat.out_free = !out_valid_q || out_ready;

	// config port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q <= POL_BEST;
			active_q <= ACTIVE_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_POLICY: policy_q <= cfg_data[POLICY_W-1:0];
				REG_ACTIVE: active_q <= cfg_data[ACTIVE_W-1:0];
				default: ;
			endcase
		end
	end

	// size memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (cmd.load && ld_in_range) begin
			size_mem[ld_addr] <= in_amount;
		end
		size_s1 <= size_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			taken_q <= '0;
		end else if (cmd.load && ld_in_range) begin
			taken_q[ld_addr] <= 1'b0;
		end else if (cmd.finish && found_q) begin
			taken_q[pick_q] <= 1'b1;
		end
	end

	// scan counter and the read stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= cmd.scan && in_limit;
			if (cmd.start) begin
				cnt_q <= '0;
			end else if (cmd.scan && in_limit) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		taken_s1 <= taken_q[rd_addr];
		idx_s1   <= rd_addr;
		if (cmd.start) begin
			amount_q <= in_amount;
			req_q    <= in_requester;
		end
	end

	// compare stage: strict compares keep ties on the lowest index
	assign fit = vld_s1 && !taken_s1 && (size_s1 >= amount_q);

	always_comb begin
		case (policy_q)
			POL_BEST:  better = size_s1 < best_q;
			POL_WORST: better = size_s1 > best_q;
			default:   better = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
			pick_q  <= '0;
			best_q  <= '0;
		end else if (cmd.start) begin
			found_q <= 1'b0;
			pick_q  <= '0;
			best_q  <= '0;
		end else if (fit && (!found_q || better)) begin
			found_q <= 1'b1;
			pick_q  <= idx_s1;
			best_q  <= size_s1;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			granted_q        <= found_q;
			chosen_index_q   <= ENTRY_W'(pick_q);
			chosen_size_q    <= best_q;
			requester_echo_q <= req_q;
		end
	end

	assign out_valid          = out_valid_q;
	assign out_granted        = granted_q;
	assign out_chosen_index   = chosen_index_q;
	assign out_chosen_size    = chosen_size_q;
	assign out_requester_echo = requester_echo_q;

endmodule

`default_nettype wire
